[design/tsps_pkg.sv]
// Shared types and constants for the spot pixel shader.
// Depends on nothing; used by tsps_isqrt and target_spot_pixel_shader.
package tsps_pkg;

  typedef enum logic [1:0] {
    REGION_INSIDE  = 2'd0,
    REGION_BAND    = 2'd1,
    REGION_OUTSIDE = 2'd2
  } region_t;

  typedef enum logic [2:0] {
    REG_SPOT_COLOR    = 3'd0,
    REG_TAN_ANGLE     = 3'd1,
    REG_Z_HEIGHT      = 3'd2,
    REG_NORM_X        = 3'd3,
    REG_NORM_Y        = 3'd4,
    REG_DECAY_RATE    = 3'd5,
    REG_INV_REFERENCE = 3'd6,
    REG_UNUSED        = 3'd7
  } reg_index_t;

  localparam logic [62:0] SAT_CAP    = 63'h4000_0000_0000_0000;
  localparam logic [16:0] ONE16      = 17'h10000;
  localparam int          SQRT_STEPS = 32;
  // input stages, square root steps, weight, first blend, output
  localparam int          PIPE_DEPTH = 5 + SQRT_STEPS + 3;

endpackage

[design/tsps_isqrt.sv]
// Pipelined 64-bit integer square root, one result bit per stage.
// Depends on tsps_pkg; carries a sideband word alongside each beat.
module tsps_isqrt
  import tsps_pkg::*;
#(
  parameter int SIDE_W = 19
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [63:0]       in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [31:0]       out_root,
  output logic [SIDE_W-1:0] out_side
);

  logic [63:0]       rem_q  [SQRT_STEPS];
  logic [63:0]       res_q  [SQRT_STEPS];
  logic [SIDE_W-1:0] side_q [SQRT_STEPS];
  logic              vld_q  [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0]       rem_i;
    logic [63:0]       res_i;
    logic [SIDE_W-1:0] side_i;
    logic              vld_i;
    logic [63:0]       trial;

    if (k == 0) begin : g_first
      assign rem_i  = in_rad;
      assign res_i  = '0;
      assign side_i = in_side;
      assign vld_i  = in_valid;
    end else begin : g_next
      assign rem_i  = rem_q[k-1];
      assign res_i  = res_q[k-1];
      assign side_i = side_q[k-1];
      assign vld_i  = vld_q[k-1];
    end

    assign trial = res_i + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      side_q[k] <= side_i;
      if (rem_i >= trial) begin
        rem_q[k] <= rem_i - trial;
        res_q[k] <= (res_i >> 1) + BIT;
      end else begin
        rem_q[k] <= rem_i;
        res_q[k] <= res_i >> 1;
      end
    end
  end

  assign out_valid = vld_q[SQRT_STEPS-1];
  assign out_root  = res_q[SQRT_STEPS-1][31:0];
  assign out_side  = side_q[SQRT_STEPS-1];

endmodule

[design/target_spot_pixel_shader.sv]
// Spot pixel shader top level: config registers, cone math, blend pipeline.
// Depends on tsps_pkg and tsps_isqrt.
// One pixel per clock, busy stays low.
// Most of the depth is the 32-stage square root, one root bit per stage.
// Results cannot be stalled; done marks each one for a single cycle.
// Synchronous reset clears the pipeline valids and loads register defaults.
module target_spot_pixel_shader
  import tsps_pkg::*;
#(
  parameter int CHANNEL_BITS = 8,
  parameter int COORD_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  output logic                    done,
  output logic [CHANNEL_BITS-1:0] red,
  output logic [CHANNEL_BITS-1:0] green,
  output logic [CHANNEL_BITS-1:0] blue,
  output logic [CHANNEL_BITS-1:0] alpha,
  output logic [1:0]              region,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int CB = COORD_BITS;
  localparam int HW = COORD_BITS + 26;
  localparam int AW = CHANNEL_BITS + 18;
  localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;

  // ---------------- configuration ----------------
  logic [31:0]        spot_color;
  logic signed [23:0] tan_angle;
  logic [23:0]        z_height;
  logic [23:0]        norm_x;
  logic [23:0]        norm_y;
  logic [17:0]        decay_rate;
  logic [23:0]        inv_reference;
  reg_index_t         reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      spot_color    <= 32'hFFFF_FFFF;
      tan_angle     <= 24'sd11556;
      z_height      <= 24'd25600;
      norm_x        <= 24'd65536;
      norm_y        <= 24'd65536;
      decay_rate    <= 18'd1678;
      inv_reference <= 24'd33554;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_SPOT_COLOR:    spot_color    <= pwdata;
        REG_TAN_ANGLE:     tan_angle     <= pwdata[23:0];
        REG_Z_HEIGHT:      z_height      <= pwdata[23:0];
        REG_NORM_X:        norm_x        <= pwdata[23:0];
        REG_NORM_Y:        norm_y        <= pwdata[23:0];
        REG_DECAY_RATE:    decay_rate    <= pwdata[17:0];
        REG_INV_REFERENCE: inv_reference <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SPOT_COLOR:    prdata = spot_color;
      REG_TAN_ANGLE:     prdata = {8'h00, tan_angle};
      REG_Z_HEIGHT:      prdata = {8'h00, z_height};
      REG_NORM_X:        prdata = {8'h00, norm_x};
      REG_NORM_Y:        prdata = {8'h00, norm_y};
      REG_DECAY_RATE:    prdata = {14'h0000, decay_rate};
      REG_INV_REFERENCE: prdata = {8'h00, inv_reference};
      default:           prdata = '0;
    endcase
  end

  // ---------------- helpers ----------------
  // (c8 * max + 127) / 255 via reciprocal 65793 / 2^24 and one correction
  function automatic logic [CHANNEL_BITS-1:0] widen(input logic [7:0] c8);
    logic [24:0] num;
    logic [41:0] prod;
    logic [24:0] q0;
    logic [24:0] rem;
    begin
      num  = 25'(c8) * 25'(CH_MAX) + 25'd127;
      prod = 42'(num) * 42'd65793;
      q0   = 25'(prod[41:24]);
      rem  = num - q0 * 25'd255;
      if (rem >= 25'd255) begin
        q0 = q0 + 25'd1;
      end
      return q0[CHANNEL_BITS-1:0];
    end
  endfunction

  // blend toward black (0, or max for alpha), round half up
  function automatic logic [CHANNEL_BITS-1:0] mix_ch(input logic [CHANNEL_BITS-1:0] c,
                                                     input logic blk_max,
                                                     input logic [16:0] w);
    logic [AW-1:0] acc;
    logic [AW-1:0] blk_term;
    begin
      blk_term = blk_max ? ((AW'(w) << CHANNEL_BITS) - AW'(w)) : '0;
      acc      = AW'(c) * AW'(ONE16 - w) + blk_term + AW'(32768);
      return acc[CHANNEL_BITS+15:16];
    end
  endfunction

  logic [CHANNEL_BITS-1:0] colw [4];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      colw[k] <= widen(spot_color[8*k +: 8]);
    end
  end

  // ---------------- pipeline ----------------
  logic v1, v2, v3, v4, v5, va, vb, vc;

  // stage 1: tilt product and scaled coordinate products
  logic [CB-1:0]        ax_in, ay_in;
  logic signed [CB+23:0] tx1;
  logic [CB+23:0]       pxa1, pya1;
  logic [CB-1:0]        ax1, ay1;

  assign ax_in = pos_x[CB-1] ? (~pos_x + 1'b1) : pos_x;
  assign ay_in = pos_y[CB-1] ? (~pos_y + 1'b1) : pos_y;

  always_ff @(posedge clk) begin
    tx1  <= tan_angle * pos_x;
    pxa1 <= ax_in * norm_x;
    pya1 <= ay_in * norm_y;
    ax1  <= ax_in;
    ay1  <= ay_in;
  end

  // stage 2: height h (Q.8, floored), partial products of the radius terms
  logic signed [HW-1:0] h16;
  logic [HW-9:0]        h8;
  logic [HW-9:0]        ah2;
  logic                 hpos2;
  logic [2*CB-1:0]      phx2, phy2;
  logic [CB+23:0]       plx2, ply2;

  assign h16 = $signed(HW'({z_height, 8'h00})) - HW'(tx1);
  assign h8  = h16[HW-1:8];

  always_ff @(posedge clk) begin
    ah2   <= h8[HW-9] ? (~h8 + 1'b1) : h8;
    hpos2 <= !h8[HW-9] && (h8 != '0);
    phx2  <= pxa1[CB+23:24] * ax1;
    plx2  <= pxa1[23:0] * ax1;
    phy2  <= pya1[CB+23:24] * ay1;
    ply2  <= pya1[23:0] * ay1;
  end

  // stage 3: h*h and radius terms, each saturated at 2^62
  logic [63:0] ah64;
  logic [61:0] hsq;
  logic [79:0] rx80, ry80;
  logic [62:0] h2_3, rx3, ry3;
  logic        hpos3;

  assign ah64 = 64'(ah2);
  assign hsq  = ah64[30:0] * ah64[30:0];
  assign rx80 = (80'(phx2) << 24) + 80'(plx2);
  assign ry80 = (80'(phy2) << 24) + 80'(ply2);

  always_ff @(posedge clk) begin
    h2_3  <= (|ah64[63:31]) ? SAT_CAP : 63'(hsq);
    rx3   <= (|rx80[79:62]) ? SAT_CAP : rx80[62:0];
    ry3   <= (|ry80[79:62]) ? SAT_CAP : ry80[62:0];
    hpos3 <= hpos2;
  end

  // stage 4: r2, discriminant and sqrt radicand
  logic [63:0]        rsum;
  logic [62:0]        r2;
  logic signed [63:0] d4;
  logic [63:0]        sum4;
  logic               hpos4;

  assign rsum = 64'(rx3) + 64'(ry3);
  assign r2   = (|rsum[63:62]) ? SAT_CAP : rsum[62:0];

  always_ff @(posedge clk) begin
    d4    <= $signed(64'(r2) - 64'(h2_3));
    sum4  <= 64'(r2) + 64'(h2_3);
    hpos4 <= hpos3;
  end

  // stage 5: region decision and falloff weight
  logic [34:0] band_lim;
  logic        in_band;
  logic [58:0] sp;
  logic [34:0] sq;
  region_t     reg_n5, reg5;
  logic [16:0] s5;
  logic [63:0] sum5;

  assign band_lim = 35'({z_height, 8'h00}) * 35'd5;
  assign in_band  = hpos4 && !d4[63] && (d4[62:35] == '0) && (d4[34:0] < band_lim);
  assign sp       = d4[34:0] * inv_reference;
  assign sq       = sp[58:24];

  always_comb begin
    priority if (hpos4 && d4[63]) begin
      reg_n5 = REGION_INSIDE;
    end else if (in_band) begin
      reg_n5 = REGION_BAND;
    end else begin
      reg_n5 = REGION_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    reg5 <= reg_n5;
    s5   <= (sq > 35'(ONE16)) ? ONE16 : sq[16:0];
    sum5 <= sum4;
  end

  // stages 6..37: square root
  logic        vs;
  logic [31:0] root;
  logic [18:0] side_out;

  tsps_isqrt #(
    .SIDE_W (19)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_rad    (sum5),
    .in_side   ({reg5, s5}),
    .out_valid (vs),
    .out_root  (root),
    .out_side  (side_out)
  );

  // stage A: distance times decay
  logic [49:0] tpa;
  region_t     rega;
  logic [16:0] sa;

  always_ff @(posedge clk) begin
    tpa  <= root * decay_rate;
    rega <= region_t'(side_out[18:17]);
    sa   <= side_out[16:0];
  end

  // stage B: clamp t and first blend
  logic [33:0]             tq;
  logic [16:0]             tw;
  logic [CHANNEL_BITS-1:0] m1b [4];
  region_t                 regb;
  logic [16:0]             sb;

  assign tq = tpa[49:16];
  assign tw = (tq > 34'(ONE16)) ? ONE16 : tq[16:0];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      m1b[k] <= mix_ch(colw[k], k == 3, tw);
    end
    regb <= rega;
    sb   <= sa;
  end

  // stage C: band blend, first blend alone inside, or black; output register
  logic [CHANNEL_BITS-1:0] px_n [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      unique case (regb)
        REGION_INSIDE: px_n[k] = m1b[k];
        REGION_BAND:   px_n[k] = mix_ch(m1b[k], k == 3, sb);
        default:       px_n[k] = (k == 3) ? CH_MAX : '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    red    <= px_n[0];
    green  <= px_n[1];
    blue   <= px_n[2];
    alpha  <= px_n[3];
    region <= regb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      va <= vs;
      vb <= va;
      vc <= vb;
    end
  end

  assign done = vc;

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, PIPE_DEPTH))
    else $error("result without matching start");

  a_outside_black : assert property (@(posedge clk) disable iff (rst)
    done && region == REGION_OUTSIDE |->
      red == '0 && green == '0 && blue == '0 && alpha == CH_MAX)
    else $error("outside pixel not black");

  a_alpha_floor : assert property (@(posedge clk) disable iff (rst)
    done |-> alpha >= colw[3])
    else $error("blend toward black lowered alpha");
`endif

endmodule

[test/tb_top.sv]
// Self-checking testbench for target_spot_pixel_shader: pixel beats on start/busy,
// results on the done strobe, registers over the APB port. Depends on tsps_pkg.
`timescale 1ns / 1ps
module tb_top;
  import tsps_pkg::*;

  typedef struct {
    logic [7:0] r, g, b, a;
    logic [1:0] rg;
  } pixel_t;

  typedef struct {
    logic signed [15:0] x, y;
    bit                 typed;
    pixel_t             px;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] pos_x = '0, pos_y = '0;
  logic done;
  logic [7:0] red, green, blue, alpha;
  logic [1:0] region;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // shadow copy of the shader registers
  logic [31:0]        sh_color;
  logic signed [23:0] sh_tan;
  logic [23:0]        sh_z, sh_nx, sh_ny, sh_inv;
  logic [17:0]        sh_decay;

  pixel_t pixel_q[$];
  int     mismatches = 0;

  target_spot_pixel_shader dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned sat_product(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = a * b;
    return (p > 128'(SAT_CAP)) ? 64'(SAT_CAP) : p[63:0];
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned acc, bitv;
    acc = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  function automatic longint unsigned fade(longint unsigned c, longint unsigned k,
                                           longint unsigned w);
    return (c * (65536 - w) + k * w + 32768) >> 16;
  endfunction

  function automatic pixel_t shade_pixel(logic signed [15:0] x, logic signed [15:0] y);
    longint h16, h8, dd;
    longint unsigned ah, ax, ay, h2, r2, n, t, s, zq;
    longint unsigned ch[4];
    pixel_t e;
    h16 = longint'(sh_z) * 256 - longint'(sh_tan) * longint'(x);
    h8 = h16 >>> 8;
    ah = (h8 < 0) ? -h8 : h8;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    ay = (y < 0) ? -longint'(y) : longint'(y);
    h2 = sat_product(ah, ah);
    r2 = sat_product(ax * ax, sh_nx) + sat_product(ay * ay, sh_ny);
    if (r2 > 64'(SAT_CAP)) r2 = 64'(SAT_CAP);
    dd = longint'(r2) - longint'(h2);
    n = root_floor(r2 + h2);
    t = (n * sh_decay) >> 16;
    if (t > 65536) t = 65536;
    zq = longint'(sh_z) << 8;
    for (int k = 0; k < 4; k++) ch[k] = sh_color[8*k +: 8];
    if (h8 > 0 && dd < 0) begin
      e.rg = REGION_INSIDE;
      for (int k = 0; k < 4; k++) ch[k] = fade(ch[k], (k == 3) ? 255 : 0, t);
    end else if (h8 > 0 && longint'(dd) < longint'(5 * zq)) begin
      s = (longint'(dd) * sh_inv) >> 24;
      if (s > 65536) s = 65536;
      e.rg = REGION_BAND;
      for (int k = 0; k < 4; k++)
        ch[k] = fade(fade(ch[k], (k == 3) ? 255 : 0, t), (k == 3) ? 255 : 0, s);
    end else begin
      e.rg = REGION_OUTSIDE;
      for (int k = 0; k < 4; k++) ch[k] = (k == 3) ? 255 : 0;
    end
    e.r = 8'(ch[0]); e.g = 8'(ch[1]); e.b = 8'(ch[2]); e.a = 8'(ch[3]);
    return e;
  endfunction

  // result checker: done cannot be held off, so every strobe is a beat
  always @(posedge clk) begin
    pixel_t e;
    if (!rst && done) begin
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h %h %h %h region %0d",
                                       red, green, blue, alpha, region);
      end else begin
        e = pixel_q.pop_front();
        if (e.r !== red || e.g !== green || e.b !== blue || e.a !== alpha ||
            e.rg !== region) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: exp %h %h %h %h r%0d got %h %h %h %h r%0d",
                     e.r, e.g, e.b, e.a, e.rg, red, green, blue, alpha, region);
        end
      end
    end
  end

  task automatic reg_write(reg_index_t idx, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SPOT_COLOR:    sh_color = v;
      REG_TAN_ANGLE:     sh_tan = v[23:0];
      REG_Z_HEIGHT:      sh_z = v[23:0];
      REG_NORM_X:        sh_nx = v[23:0];
      REG_NORM_Y:        sh_ny = v[23:0];
      REG_DECAY_RATE:    sh_decay = v[17:0];
      REG_INV_REFERENCE: sh_inv = v[23:0];
      default: ;
    endcase
  endtask

  // one pixel beat; start is left high so back-to-back beats need no toggle
  task automatic send_pixel(logic signed [15:0] x, logic signed [15:0] y,
                            bit typed, pixel_t px);
    start <= 1'b1; pos_x <= x; pos_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    pixel_q.push_back(typed ? px : shade_pixel(x, y));
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  task automatic phase_config(int ph);
    int zi;
    case (ph)
      0: ;
      1: begin
        reg_write(REG_SPOT_COLOR, 32'hFFFF_FFFF);
        reg_write(REG_TAN_ANGLE, 32'h007F_FFFF);
        reg_write(REG_Z_HEIGHT, 32'h00FF_FFFF);
        reg_write(REG_NORM_X, 32'h00FF_FFFF);
        reg_write(REG_NORM_Y, 32'h00FF_FFFF);
        reg_write(REG_DECAY_RATE, 32'd167772);
        reg_write(REG_INV_REFERENCE, 32'h00FF_FFFF);
      end
      2: begin
        reg_write(REG_SPOT_COLOR, 32'h0000_0000);
        reg_write(REG_TAN_ANGLE, 32'h0080_0000);
        reg_write(REG_Z_HEIGHT, 32'h0);
        reg_write(REG_NORM_X, 32'h0);
        reg_write(REG_NORM_Y, 32'h0);
        reg_write(REG_DECAY_RATE, 32'h0);
        reg_write(REG_INV_REFERENCE, 32'h00FF_FFFF);
      end
      default: begin
        zi = $urandom_range(4, 200);
        reg_write(REG_SPOT_COLOR, $urandom);
        reg_write(REG_TAN_ANGLE, 32'(signed'($urandom_range(0, 262144)) - 131072));
        reg_write(REG_Z_HEIGHT, zi * 256 + $urandom_range(0, 255));
        reg_write(REG_NORM_X, $urandom_range(4096, 262144));
        reg_write(REG_NORM_Y, $urandom_range(4096, 262144));
        reg_write(REG_DECAY_RATE, $urandom_range(0, 167772));
        // 1/(5z) in Q0.24, with d in Q.16 units
        reg_write(REG_INV_REFERENCE,
                  32'((ph % 3 == 0) ? 64'($urandom_range(0, 24'hFFFFFF))
                                    : (64'd1 << 40) / (5 * 256 * zi * 256)));
      end
    endcase
  endtask

  initial begin
    stim_row_t rows[$];
    pixel_t blk;
    int idle_pct, span;
    logic signed [15:0] x, y;
    blk.r = 0; blk.g = 0; blk.b = 0; blk.a = 8'hFF; blk.rg = REGION_OUTSIDE;
    sh_color = 32'hFFFF_FFFF; sh_tan = 24'sd11556; sh_z = 24'd25600;
    sh_nx = 24'd65536; sh_ny = 24'd65536; sh_decay = 18'd1678; sh_inv = 24'd33554;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default registers: far right of the tilt puts the height below zero
    rows = '{
      '{16'sd32767, 16'sd0, 1'b1, blk},
      '{16'sd32767, 16'sd32767, 1'b1, blk},
      '{16'sd32767, -16'sd32768, 1'b1, blk},
      '{16'sd0, 16'sd0, 1'b0, blk},
      '{-16'sd32768, -16'sd32768, 1'b0, blk},
      '{-16'sd32768, 16'sd32767, 1'b0, blk},
      '{16'sd1, 16'sd0, 1'b0, blk},
      '{-16'sd1, -16'sd1, 1'b0, blk},
      '{16'sd0, 16'sd95, 1'b0, blk},
      '{16'sd0, 16'sd100, 1'b0, blk},
      '{16'sd0, 16'sd105, 1'b0, blk},
      '{16'sd70, 16'sd70, 1'b0, blk},
      '{16'sd0, -16'sd200, 1'b0, blk},
      '{16'sd566, 16'sd0, 1'b0, blk},
      '{16'sd567, 16'sd0, 1'b0, blk}
    };
    foreach (rows[i]) send_pixel(rows[i].x, rows[i].y, rows[i].typed, rows[i].px);
    drain();
    // zero height: everything is black
    reg_write(REG_Z_HEIGHT, 32'h0);
    reg_write(REG_TAN_ANGLE, 32'h0);
    send_pixel(16'sd0, 16'sd0, 1'b1, blk);
    send_pixel(16'sd3, -16'sd4, 1'b1, blk);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      phase_config(ph);
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 53 : 34;
      span = (sh_z >> 8) * 2 + 8;
      if (span > 32767) span = 32767;
      for (int i = 0; i < 185; i++) begin
        case ($urandom_range(0, 3))
          0, 1: begin
            x = 16'($urandom_range(0, 2 * span) - span);
            y = 16'($urandom_range(0, 2 * span) - span);
          end
          2: begin
            x = 16'($urandom_range(0, 4095) - 2048);
            y = 16'($urandom_range(0, 4095) - 2048);
          end
          default: begin
            x = 16'($urandom);
            y = 16'($urandom);
          end
        endcase
        send_pixel(x, y, 1'b0, blk);
        if ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      drain();
    end

    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
